@@ sv/d2wp_pkg.sv @@
// Shared types and constants for the disparity to world point block.
// Depends on nothing; the configuration interface and every module of the block import it.
package d2wp_pkg;

    // Fixed widths of the arithmetic path.
    localparam int NUM_W     = 40;
    localparam int DEN_W     = 15;
    localparam int REM_W     = 15;
    localparam int POSE_N    = 12;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 65;
    localparam int TRANS_W   = 41;

    // Input item opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL     = 3'd0,
        CFG_BASELINE  = 3'd1,
        CFG_PRINC_U   = 3'd2,
        CFG_PRINC_V   = 3'd3,
        CFG_MIN_DEPTH = 3'd4,
        CFG_MAX_DEPTH = 3'd5
    } cfg_idx_t;

    // Current configuration register values.
    typedef struct packed {
        logic [15:0] focal_length;
        logic [15:0] stereo_baseline;
        logic [15:0] principal_u;
        logic [15:0] principal_v;
        logic [31:0] min_depth;
        logic [31:0] max_depth;
    } cfg_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic             is_load;
        logic [IDX_W-1:0] coef_idx;
        logic [31:0]      coef_val;
        logic [7:0]       intensity;
        logic [DEN_W-1:0] den;
        logic             neg_x;
        logic             neg_y;
        logic [NUM_W-1:0] num_z;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
    } work_t;

endpackage

@@ sv/d2wp_pixel_if.sv @@
// Input channel carrying one pixel or pose load item.
// Depends on nothing.
interface d2wp_pixel_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [10:0]        pixel_column;
    logic [10:0]        pixel_row;
    logic signed [15:0] disparity;
    logic [7:0]         intensity;
    logic [3:0]         coefficient_index;
    logic signed [31:0] coefficient_value;

    modport source (output valid, output opcode, output pixel_column, output pixel_row,
                    output disparity, output intensity, output coefficient_index,
                    output coefficient_value, input ready);
    modport sink (input valid, input opcode, input pixel_column, input pixel_row,
                  input disparity, input intensity, input coefficient_index,
                  input coefficient_value, output ready);
endinterface

@@ sv/d2wp_point_if.sv @@
// Output channel carrying one world point item.
// Depends on nothing.
interface d2wp_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         point_intensity;

    modport source (output valid, output world_x, output world_y, output world_z,
                    output point_intensity, input ready);
    modport sink (input valid, input world_x, input world_y, input world_z,
                  input point_intensity, output ready);
endinterface

@@ sv/d2wp_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on d2wp_pkg for the index width.
interface d2wp_cfg_if;
    import d2wp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/d2wp_front.sv @@
// Front end: accepts items, drops those that give no result, forms the numerators.
// Depends on d2wp_pkg and d2wp_pixel_if.
module d2wp_front #(
    parameter int MAX_IMAGE_WIDTH     = 2048,
    parameter int MAX_IMAGE_HEIGHT    = 2048,
    parameter int COORD_FRACTION_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  d2wp_pkg::cfg_t  cfg_regs,
    d2wp_pixel_if.sink      pixel,
    output logic            push,
    output d2wp_pkg::work_t push_item,
    input  logic            full
);
    import d2wp_pkg::*;

    localparam int UP_SHIFT = (COORD_FRACTION_BITS >= 16) ? COORD_FRACTION_BITS - 16 : 0;
    localparam int DIM_W    = 14;

    logic               accept;
    logic               keep;
    logic               in_range;
    logic               disp_pos;
    logic [31:0]        fb;
    logic signed [16:0] diff_u;
    logic signed [16:0] diff_v;
    logic [15:0]        abs_u;
    logic [15:0]        abs_v;
    logic [31:0]        prod_u;
    logic [31:0]        prod_v;
    work_t              item_next;
    work_t              item_reg;
    logic               valid_reg;

    assign pixel.ready = !valid_reg || !full;
    assign accept      = pixel.valid && pixel.ready;

    // Classify the item: loads to a real pose entry and pixels that can give a point.
    always_comb
    begin
        in_range = ({3'b000, pixel.pixel_column} < DIM_W'(MAX_IMAGE_WIDTH))
                && ({3'b000, pixel.pixel_row} < DIM_W'(MAX_IMAGE_HEIGHT));
        disp_pos = !pixel.disparity[15] && (pixel.disparity != 16'sd0);
        if (pixel.opcode == OP_LOAD)
        begin
            keep = pixel.coefficient_index < IDX_W'(POSE_N);
        end
        else
        begin
            keep = (pixel.opcode == OP_PIXEL) && in_range && disp_pos;
        end
    end

    // Numerators: focal times baseline for depth, offset times baseline for x and y.
    always_comb
    begin
        fb     = cfg_regs.focal_length * cfg_regs.stereo_baseline;
        diff_u = $signed({2'b00, pixel.pixel_column, 4'b0000})
               - $signed({1'b0, cfg_regs.principal_u});
        diff_v = $signed({2'b00, pixel.pixel_row, 4'b0000})
               - $signed({1'b0, cfg_regs.principal_v});
        abs_u  = diff_u[16] ? 16'(-diff_u) : diff_u[15:0];
        abs_v  = diff_v[16] ? 16'(-diff_v) : diff_v[15:0];
        prod_u = abs_u * cfg_regs.stereo_baseline;
        prod_v = abs_v * cfg_regs.stereo_baseline;

        item_next.is_load   = pixel.opcode == OP_LOAD;
        item_next.coef_idx  = pixel.coefficient_index;
        item_next.coef_val  = pixel.coefficient_value;
        item_next.intensity = pixel.intensity;
        item_next.den       = pixel.disparity[DEN_W-1:0];
        item_next.neg_x     = diff_u[16];
        item_next.neg_y     = diff_v[16];
        item_next.num_z     = NUM_W'(fb) << UP_SHIFT;
        item_next.num_x     = NUM_W'(prod_u) << UP_SHIFT;
        item_next.num_y     = NUM_W'(prod_v) << UP_SHIFT;
    end

    // Output register toward the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            valid_reg <= accept && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel.ready)
        begin
            item_reg <= item_next;
        end
    end

    assign push      = valid_reg && !full;
    assign push_item = item_reg;

endmodule

@@ sv/d2wp_queue.sv @@
// Short item queue between the front and the back.
// Depends on d2wp_pkg for the item type.
module d2wp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  d2wp_pkg::work_t push_item,
    output logic            full,
    input  logic            pop,
    output d2wp_pkg::work_t head,
    output logic            empty
);
    import d2wp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t             slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

@@ sv/d2wp_back.sv @@
// Back end: pipelined divider, depth window, pose transform and output register.
// Depends on d2wp_pkg and d2wp_point_if.
module d2wp_back #(
    parameter int COORD_FRACTION_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  d2wp_pkg::cfg_t  cfg_regs,
    input  d2wp_pkg::work_t head,
    input  logic            empty,
    output logic            pop,
    d2wp_point_if.source    point
);
    import d2wp_pkg::*;

    localparam int UP_SHIFT   = (COORD_FRACTION_BITS >= 16) ? COORD_FRACTION_BITS - 16 : 0;
    localparam int DOWN_SHIFT = (COORD_FRACTION_BITS < 16) ? 16 - COORD_FRACTION_BITS : 0;
    localparam int STEP_BITS  = 2;
    localparam int NS         = NUM_W / STEP_BITS;
    localparam int SUM_W      = 52;

    typedef struct packed {
        work_t            w;
        logic [REM_W-1:0] rem_z;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
    } div_t;

    // Restoring division, two quotient bits per call.
    function automatic logic [REM_W+NUM_W-1:0] div_step(
        input logic [REM_W-1:0] rem,
        input logic [NUM_W-1:0] quo,
        input logic [DEN_W-1:0] den
    );
        logic [REM_W-1:0] r;
        logic [NUM_W-1:0] q;
        logic [REM_W:0]   t;
        r = rem;
        q = quo;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, q[NUM_W-1]};
            if (t >= {1'b0, den})
            begin
                r = REM_W'(t - {1'b0, den});
                q = {q[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r = t[REM_W-1:0];
                q = {q[NUM_W-2:0], 1'b0};
            end
        end
        return {r, q};
    endfunction

    // Signed 32-bit value from sign and magnitude, saturated.
    function automatic logic [31:0] sat_mag(input logic neg, input logic [NUM_W-1:0] mag);
        logic [31:0] res;
        if (neg)
        begin
            res = (mag > NUM_W'(32'h8000_0000)) ? 32'h8000_0000 : -mag[31:0];
        end
        else
        begin
            res = (mag > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return res;
    endfunction

    // Signed sum clamped to 32 bits.
    function automatic logic [31:0] sat_sum(input logic signed [SUM_W-1:0] s);
        logic [31:0] res;
        if ((s[SUM_W-1:31] == '0) || (s[SUM_W-1:31] == '1))
        begin
            res = s[31:0];
        end
        else
        begin
            res = s[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    logic en;
    div_t stage_in   [NS];
    div_t stage_next [NS];
    div_t stage_reg  [NS];
    logic stage_valid_in  [NS];
    logic stage_valid_reg [NS];

    // Whole back pipeline advances while the output register can take a result.
    assign en  = !point.valid || point.ready;
    assign pop = en && !empty;

    always_comb
    begin
        stage_in[0].w     = head;
        stage_in[0].rem_z = '0;
        stage_in[0].rem_x = '0;
        stage_in[0].rem_y = '0;
        stage_valid_in[0] = !empty;
    end

    // Divider stages: three quotients share one disparity per item.
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        if (k > 0)
        begin : g_link
            assign stage_in[k]       = stage_reg[k-1];
            assign stage_valid_in[k] = stage_valid_reg[k-1];
        end

        always_comb
        begin
            stage_next[k] = stage_in[k];
            {stage_next[k].rem_z, stage_next[k].w.num_z} =
                div_step(stage_in[k].rem_z, stage_in[k].w.num_z, stage_in[k].w.den);
            {stage_next[k].rem_x, stage_next[k].w.num_x} =
                div_step(stage_in[k].rem_x, stage_in[k].w.num_x, stage_in[k].w.den);
            {stage_next[k].rem_y, stage_next[k].w.num_y} =
                div_step(stage_in[k].rem_y, stage_in[k].w.num_y, stage_in[k].w.den);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                stage_valid_reg[k] <= stage_valid_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Quotient scaling, depth window and saturation of camera x and y.
    logic [NUM_W-1:0] zq;
    logic [NUM_W-1:0] xq;
    logic [NUM_W-1:0] yq;
    logic             in_window;
    work_t            last_w;
    logic             last_valid;

    logic             p1_load_reg;
    logic             p1_point_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic [31:0]      p1_val_reg;
    logic [7:0]       p1_int_reg;
    logic [31:0]      p1_x_reg;
    logic [31:0]      p1_y_reg;
    logic [32:0]      p1_z_reg;

    assign last_w     = stage_reg[NS-1].w;
    assign last_valid = stage_valid_reg[NS-1];

    always_comb
    begin
        zq        = last_w.num_z >> DOWN_SHIFT;
        xq        = last_w.num_x >> DOWN_SHIFT;
        yq        = last_w.num_y >> DOWN_SHIFT;
        in_window = (zq > NUM_W'(cfg_regs.min_depth)) && (zq < NUM_W'(cfg_regs.max_depth));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_load_reg  <= 1'b0;
            p1_point_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_load_reg  <= last_valid && last_w.is_load;
            p1_point_reg <= last_valid && !last_w.is_load && in_window;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_idx_reg <= last_w.coef_idx;
            p1_val_reg <= last_w.coef_val;
            p1_int_reg <= last_w.intensity;
            p1_x_reg   <= sat_mag(last_w.neg_x, xq);
            p1_y_reg   <= sat_mag(last_w.neg_y, yq);
            p1_z_reg   <= {1'b0, zq[31:0]};
        end
    end

    // Pose store, written in item order by load items.
    logic [31:0] pose_reg [POSE_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POSE_N; i++)
            begin
                pose_reg[i] <= '0;
            end
        end
        else if (en && p1_load_reg)
        begin
            pose_reg[p1_idx_reg] <= p1_val_reg;
        end
    end

    // Pose products and translation terms, one register stage.
    logic                      p2_point_reg;
    logic [7:0]                p2_int_reg;
    logic signed [PROD_W-1:0]  prod_next [3][3];
    logic signed [PROD_W-1:0]  prod_reg  [3][3];
    logic signed [TRANS_W-1:0] trans_next [3];
    logic signed [TRANS_W-1:0] trans_reg  [3];

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        always_comb
        begin
            prod_next[r][0] = $signed(pose_reg[r*4])   * $signed(p1_x_reg);
            prod_next[r][1] = $signed(pose_reg[r*4+1]) * $signed(p1_y_reg);
            prod_next[r][2] = $signed(pose_reg[r*4+2]) * $signed(p1_z_reg);
            trans_next[r]   = TRANS_W'($signed(pose_reg[r*4+3]));
            trans_next[r]   = (trans_next[r] <<< UP_SHIFT) >>> DOWN_SHIFT;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[r][0] <= prod_next[r][0];
                prod_reg[r][1] <= prod_next[r][1];
                prod_reg[r][2] <= prod_next[r][2];
                trans_reg[r]   <= trans_next[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_point_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_point_reg <= p1_point_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_int_reg <= p1_int_reg;
        end
    end

    // Row sums with floor scaling, saturated into the output register.
    logic signed [SUM_W-1:0] sum [3];
    logic                    out_valid_reg;
    logic [31:0]             world_reg [3];
    logic [7:0]              out_int_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = SUM_W'(prod_reg[r][0] >>> 16) + SUM_W'(prod_reg[r][1] >>> 16)
                   + SUM_W'(prod_reg[r][2] >>> 16) + SUM_W'(trans_reg[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p2_point_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                world_reg[r] <= sat_sum(sum[r]);
            end
            out_int_reg <= p2_int_reg;
        end
    end

    assign point.valid           = out_valid_reg;
    assign point.world_x         = world_reg[0];
    assign point.world_y         = world_reg[1];
    assign point.world_z         = world_reg[2];
    assign point.point_intensity = out_int_reg;

endmodule

@@ sv/disparity_to_world_point.sv @@
// Top level of the stereo disparity to world point block: configuration registers,
// front end, item queue and back end. Depends on d2wp_pkg, the interfaces and submodules.
//
//   Port    Direction  Carries
//   pixel   in         opcode, pixel_column, pixel_row, disparity, intensity,
//                      coefficient_index, coefficient_value
//   point   out        world_x, world_y, world_z, point_intensity
//   cfg     in         index, data (register write, always ready)
//
// One item per clock is accepted while the output is taken. A point is offered once its
// pixel item has passed the front register, one queue write, 20 divider stages at two
// quotient bits each, and three transform stages. Reset clears control state, loads the
// register defaults and zeroes the pose. A stalled output freezes the back end; the
// four-entry queue lets the front keep accepting until it fills.
module disparity_to_world_point #(
    parameter int MAX_IMAGE_WIDTH     = 2048,
    parameter int MAX_IMAGE_HEIGHT    = 2048,
    parameter int COORD_FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    d2wp_pixel_if.sink   pixel,
    d2wp_point_if.source point,
    d2wp_cfg_if.sink     cfg
);
    import d2wp_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    cfg_t  cfg_reg;
    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    work_t push_item;
    work_t head;

    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_length    <= 16'd11200;
            cfg_reg.stereo_baseline <= 16'd35389;
            cfg_reg.principal_u     <= 16'd9752;
            cfg_reg.principal_v     <= 16'd2765;
            cfg_reg.min_depth       <= 32'd6554;
            cfg_reg.max_depth       <= 32'd1310720;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_FOCAL:     cfg_reg.focal_length    <= cfg.data[15:0];
                CFG_BASELINE:  cfg_reg.stereo_baseline <= cfg.data[15:0];
                CFG_PRINC_U:   cfg_reg.principal_u     <= cfg.data[15:0];
                CFG_PRINC_V:   cfg_reg.principal_v     <= cfg.data[15:0];
                CFG_MIN_DEPTH: cfg_reg.min_depth       <= cfg.data;
                CFG_MAX_DEPTH: cfg_reg.max_depth       <= cfg.data;
                default:       ;
            endcase
        end
    end

    d2wp_front #(
        .MAX_IMAGE_WIDTH     (MAX_IMAGE_WIDTH),
        .MAX_IMAGE_HEIGHT    (MAX_IMAGE_HEIGHT),
        .COORD_FRACTION_BITS (COORD_FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_reg),
        .pixel     (pixel),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    d2wp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    d2wp_back #(
        .COORD_FRACTION_BITS (COORD_FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .point    (point)
    );

endmodule
